### design/additive_sine_frame_synth_assert.svh
// Assertion macros for the additive sine frame synthesizer.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef ADDITIVE_SINE_FRAME_SYNTH_ASSERT_SVH
`define ADDITIVE_SINE_FRAME_SYNTH_ASSERT_SVH

`define ASFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define ASFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### design/asfs_pkg.sv
// Shared types and constants of the additive sine frame synthesizer.
// No dependencies.
`default_nettype none

package asfs_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int COS_W     = 17;
  localparam int MUL_A_W   = 32;
  localparam int MUL_B_W   = 24;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [15:0] UNITY_MUL = 16'd256;

  typedef struct packed {
    logic               peak_valid;
    logic        [23:0] peak_freq;
    logic        [15:0] peak_amp;
    logic signed [15:0] peak_phase;
    logic signed [15:0] peak_group;
    logic               last_peak;
  } peak_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP = 3'd0,
    CFG_DELAY      = 3'd1,
    CFG_HARM_CNT   = 3'd2,
    CFG_MUL_FREQ_1 = 3'd3,
    CFG_MUL_AMP_1  = 3'd4,
    CFG_MUL_FREQ_2 = 3'd5,
    CFG_MUL_AMP_2  = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FE,
    S_AE,
    S_LO,
    S_HI,
    S_SUM,
    S_OFF,
    S_PH,
    S_RUN,
    S_DRAIN,
    S_NEXT,
    S_EMIT_RD,
    S_EMIT_LD
  } asfs_state_e;

endpackage

`default_nettype wire

### design/additive_sine_frame_synth.sv
// Additive sine frame synthesizer: accepts one peak word at a time and adds its
// sinusoid (one or two harmonic passes) into a FRAME_LEN-sample accumulator; a
// word marked last_peak then drains the frame out as FRAME_LEN sample words and
// clears it. Each pass runs seven setup steps on the one shared 32x24
// multiplier (frequency, amplitude, two phase-increment partial products, start
// offset), then one sample per cycle through the cosine table, multiplier and
// accumulator, then a drain of the sample pipeline and a pass end (S_NEXT).
// A skipped peak runs no pass; a pass with zero frequency or amplitude ends
// without a run. Emitting a frame reads each sample (S_EMIT_RD), then loads it
// into the output register (S_EMIT_LD), waiting there on any output stall.
// The input is not ready while a word is in progress.
// Depends on asfs_pkg, asfs_mult, asfs_cos_rom, asfs_frame_mem.
`default_nettype none

module additive_sine_frame_synth #(
  parameter int FRAME_LEN      = 64,
  parameter int COS_TABLE_BITS = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  asfs_pkg::peak_t                  in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output asfs_pkg::sample_t                out_word_o,
  input  logic                             cfg_we_i,
  input  logic [asfs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [asfs_pkg::CFG_W-1:0]       cfg_wdata_i
);

  `include "additive_sine_frame_synth_assert.svh"

  localparam int AddrW = $clog2(FRAME_LEN);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(FRAME_LEN - 1);
  localparam logic signed [34:0] SatMax = 35'sd8388607;
  localparam logic signed [34:0] SatMin = -35'sd8388608;

  // configuration
  logic [31:0] step_q;
  logic [6:0]  delay_q;
  logic [1:0]  hc_q;
  logic [15:0] mf1_q, ma1_q, mf2_q, ma2_q;

  // sequencer
  asfs_pkg::asfs_state_e state_q, state_d;
  asfs_pkg::peak_t       item_q;
  logic                  pass_q;
  logic [AddrW-1:0]      cnt_q;
  logic                  rom_en;
  logic                  out_load;
  logic                  mem_rd_en;
  logic [AddrW-1:0]      mem_rd_addr;
  logic                  mem_clr;

  // setup results
  logic [39:0] fe_q;
  logic [31:0] ae_q;
  logic [31:0] inc_lo_q;
  logic [31:0] inc_q;
  logic [31:0] ph_q;

  // sample pipeline
  logic             v1_q, v2_q, v3_q;
  logic             pipe_busy;
  logic [AddrW-1:0] a1_q, a2_q, a3_q;
  logic             neg2_q;
  logic signed [32:0] contrib_q;
  logic signed [32:0] contrib_d;
  logic [49:0]        rnd;
  logic signed [34:0] sum_d;
  logic signed [asfs_pkg::SAMPLE_W-1:0] sat_d;

  // shared units
  logic [asfs_pkg::MUL_A_W-1:0] mul_a;
  logic [asfs_pkg::MUL_B_W-1:0] mul_b;
  logic [asfs_pkg::PROD_W-1:0]  prod;
  logic [15:0]                  sel_mf, sel_ma;
  logic [asfs_pkg::COS_W-1:0]   cos_mag;
  logic                         cos_neg;
  logic signed [asfs_pkg::SAMPLE_W-1:0] mem_rd_data;

  asfs_pkg::sample_t out_word_q;
  logic              out_valid_q;

  asfs_mult u_mult (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  asfs_cos_rom #(
    .TableBits (COS_TABLE_BITS)
  ) u_cos_rom (
    .clk_i   (clk_i),
    .rd_en_i (rom_en),
    .phase_i (ph_q),
    .mag_o   (cos_mag),
    .neg_o   (cos_neg)
  );

  asfs_frame_mem #(
    .Depth (FRAME_LEN)
  ) u_frame_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .clr_en_i  (mem_clr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (v3_q),
    .wr_addr_i (a3_q),
    .wr_data_i (sat_d)
  );

  // next state and control
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_load    = 1'b0;
    rom_en      = 1'b0;
    mem_rd_en   = v2_q;
    mem_rd_addr = a2_q;
    mem_clr     = 1'b0;
    case (state_q)
      asfs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_word_i.peak_valid && !in_word_i.peak_group[15]) begin
            state_d = asfs_pkg::S_FE;
          end else if (in_word_i.last_peak) begin
            state_d = asfs_pkg::S_EMIT_RD;
          end
        end
      end
      asfs_pkg::S_FE:  state_d = asfs_pkg::S_AE;
      asfs_pkg::S_AE:  state_d = asfs_pkg::S_LO;
      asfs_pkg::S_LO: begin
        if (fe_q == '0 || prod[31:0] == '0) begin
          state_d = asfs_pkg::S_NEXT;
        end else begin
          state_d = asfs_pkg::S_HI;
        end
      end
      asfs_pkg::S_HI:  state_d = asfs_pkg::S_SUM;
      asfs_pkg::S_SUM: state_d = asfs_pkg::S_OFF;
      asfs_pkg::S_OFF: state_d = asfs_pkg::S_PH;
      asfs_pkg::S_PH:  state_d = asfs_pkg::S_RUN;
      asfs_pkg::S_RUN: begin
        rom_en = 1'b1;
        if (cnt_q == LastAddr) begin
          state_d = asfs_pkg::S_DRAIN;
        end
      end
      asfs_pkg::S_DRAIN: begin
        if (!v1_q && !v2_q && !v3_q) begin
          state_d = asfs_pkg::S_NEXT;
        end
      end
      asfs_pkg::S_NEXT: begin
        if (!pass_q && hc_q[1]) begin
          state_d = asfs_pkg::S_FE;
        end else if (item_q.last_peak) begin
          state_d = asfs_pkg::S_EMIT_RD;
        end else begin
          state_d = asfs_pkg::S_IDLE;
        end
      end
      asfs_pkg::S_EMIT_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = cnt_q;
        mem_clr     = 1'b1;
        state_d     = asfs_pkg::S_EMIT_LD;
      end
      asfs_pkg::S_EMIT_LD: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          if (cnt_q == LastAddr) begin
            state_d = asfs_pkg::S_IDLE;
          end else begin
            state_d = asfs_pkg::S_EMIT_RD;
          end
        end
      end
      default: state_d = asfs_pkg::S_IDLE;
    endcase
  end

  // multiplier operand select
  always_comb begin
    if (pass_q) begin
      sel_mf = mf2_q;
      sel_ma = ma2_q;
    end else if (hc_q == 2'd0) begin
      sel_mf = asfs_pkg::UNITY_MUL;
      sel_ma = asfs_pkg::UNITY_MUL;
    end else begin
      sel_mf = mf1_q;
      sel_ma = ma1_q;
    end
    case (state_q)
      asfs_pkg::S_FE: begin
        mul_a = asfs_pkg::MUL_A_W'(item_q.peak_freq);
        mul_b = asfs_pkg::MUL_B_W'(sel_mf);
      end
      asfs_pkg::S_AE: begin
        mul_a = asfs_pkg::MUL_A_W'(item_q.peak_amp);
        mul_b = asfs_pkg::MUL_B_W'(sel_ma);
      end
      asfs_pkg::S_LO: begin
        mul_a = step_q;
        mul_b = fe_q[23:0];
      end
      asfs_pkg::S_HI: begin
        mul_a = step_q;
        mul_b = asfs_pkg::MUL_B_W'(fe_q[39:24]);
      end
      asfs_pkg::S_OFF: begin
        mul_a = inc_q;
        mul_b = asfs_pkg::MUL_B_W'(delay_q);
      end
      default: begin
        mul_a = ae_q;
        mul_b = asfs_pkg::MUL_B_W'(cos_mag);
      end
    endcase
  end

  // round ae*|cos| / 2^17 half away from zero, then saturating add
  always_comb begin
    rnd = ({1'b0, prod[48:0]} + 50'd65536) >> 17;
    if (neg2_q) begin
      contrib_d = -$signed({1'b0, rnd[31:0]});
    end else begin
      contrib_d = $signed({1'b0, rnd[31:0]});
    end
    sum_d = {{2{contrib_q[32]}}, contrib_q}
          + {{(35 - asfs_pkg::SAMPLE_W){mem_rd_data[asfs_pkg::SAMPLE_W-1]}}, mem_rd_data};
    if (sum_d > SatMax) begin
      sat_d = SatMax[asfs_pkg::SAMPLE_W-1:0];
    end else if (sum_d < SatMin) begin
      sat_d = SatMin[asfs_pkg::SAMPLE_W-1:0];
    end else begin
      sat_d = sum_d[asfs_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= asfs_pkg::S_IDLE;
      pass_q      <= 1'b0;
      cnt_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= 32'd97391;
      delay_q     <= 7'd32;
      hc_q        <= 2'd0;
      mf1_q       <= asfs_pkg::UNITY_MUL;
      ma1_q       <= asfs_pkg::UNITY_MUL;
      mf2_q       <= asfs_pkg::UNITY_MUL;
      ma2_q       <= asfs_pkg::UNITY_MUL;
    end else begin
      state_q <= state_d;
      v1_q    <= rom_en;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (asfs_pkg::cfg_reg_e'(cfg_idx_i))
          asfs_pkg::CFG_PHASE_STEP: step_q  <= cfg_wdata_i;
          asfs_pkg::CFG_DELAY:      delay_q <= cfg_wdata_i[6:0];
          asfs_pkg::CFG_HARM_CNT:   hc_q    <= cfg_wdata_i[1:0];
          asfs_pkg::CFG_MUL_FREQ_1: mf1_q   <= cfg_wdata_i[15:0];
          asfs_pkg::CFG_MUL_AMP_1:  ma1_q   <= cfg_wdata_i[15:0];
          asfs_pkg::CFG_MUL_FREQ_2: mf2_q   <= cfg_wdata_i[15:0];
          asfs_pkg::CFG_MUL_AMP_2:  ma2_q   <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      case (state_q)
        asfs_pkg::S_IDLE: begin
          if (in_valid_i) begin
            pass_q <= 1'b0;
            cnt_q  <= '0;
          end
        end
        asfs_pkg::S_PH:  cnt_q <= '0;
        asfs_pkg::S_RUN: cnt_q <= cnt_q + 1'b1;
        asfs_pkg::S_NEXT: begin
          cnt_q <= '0;
          if (!pass_q && hc_q[1]) begin
            pass_q <= 1'b1;
          end
        end
        asfs_pkg::S_EMIT_LD: begin
          if (out_load) begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_word_i;
    end
    case (state_q)
      asfs_pkg::S_AE:  fe_q     <= prod[39:0];
      asfs_pkg::S_LO:  ae_q     <= prod[31:0];
      asfs_pkg::S_HI:  inc_lo_q <= prod[47:16];
      asfs_pkg::S_SUM: inc_q    <= inc_lo_q + {prod[23:0], 8'd0};
      asfs_pkg::S_PH:  ph_q     <= {item_q.peak_phase, 16'd0} - prod[31:0];
      asfs_pkg::S_RUN: ph_q     <= ph_q + inc_q;
      default: ;
    endcase
    a1_q      <= cnt_q;
    a2_q      <= a1_q;
    a3_q      <= a2_q;
    neg2_q    <= cos_neg;
    contrib_q <= contrib_d;
    if (out_load) begin
      out_word_q.sample      <= mem_rd_data;
      out_word_q.last_sample <= (cnt_q == LastAddr);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign pipe_busy = v1_q | v2_q | v3_q;

  `ASFS_ASSERT(a_idle_pipe_empty, in_ready_o |-> !pipe_busy, "word accepted with samples in flight")
  `ASFS_ASSERT_IMP(a_drain_exit_empty, state_q == asfs_pkg::S_DRAIN && state_d != state_q, !pipe_busy, "drain left early")
  `ASFS_ASSERT_IMP(a_second_pass_cfg, pass_q && state_q != asfs_pkg::S_IDLE, hc_q[1], "second pass without two pairs")
  `ASFS_ASSERT_IMP(a_no_write_in_emit, state_q == asfs_pkg::S_EMIT_RD || state_q == asfs_pkg::S_EMIT_LD, !v3_q, "write during readout")

endmodule

`default_nettype wire

### design/asfs_mult.sv
// Shared unsigned multiplier with a registered product.
// Depends on asfs_pkg for operand widths.
`default_nettype none

module asfs_mult (
  input  logic                         clk_i,
  input  logic [asfs_pkg::MUL_A_W-1:0] a_i,
  input  logic [asfs_pkg::MUL_B_W-1:0] b_i,
  output logic [asfs_pkg::PROD_W-1:0]  p_o
);

  logic [asfs_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= asfs_pkg::PROD_W'(a_i) * asfs_pkg::PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

### design/asfs_cos_rom.sv
// Quarter-wave cosine table with quadrant folding and registered read.
// Depends on asfs_pkg; table contents are computed at elaboration.
`default_nettype none

module asfs_cos_rom #(
  parameter int TableBits = 10
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [31:0]                phase_i,
  output logic [asfs_pkg::COS_W-1:0] mag_o,
  output logic                       neg_o
);

  localparam int QSize = 1 << TableBits;
  localparam logic [63:0] PiHalfQ30 = 64'd1686629713;
  localparam logic [9:0] TaylorDiv [12] = '{
    10'd2, 10'd12, 10'd30, 10'd56, 10'd90, 10'd132,
    10'd182, 10'd240, 10'd306, 10'd380, 10'd462, 10'd552
  };

  typedef logic [asfs_pkg::COS_W-1:0] rom_t [QSize+1];

  // 12-term Taylor series in Q30, rounded to Q16
  function automatic logic [asfs_pkg::COS_W-1:0] cos_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      v;
    x    = (PiHalfQ30 * 64'(k)) >> TableBits;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = 64'sd1 <<< 30;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / 64'(TaylorDiv[n-1]);
      if ((n % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum + 8192) >>> 14;
    if (v > 65536) begin
      v = 65536;
    end
    return v[asfs_pkg::COS_W-1:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k <= QSize; k++) begin
      r[k] = cos_entry(k);
    end
    return r;
  endfunction

  localparam rom_t CosRom = build_rom();

  logic [TableBits-1:0]       k_idx;
  logic [TableBits:0]         rom_idx;
  logic [asfs_pkg::COS_W-1:0] mag_q;
  logic                       neg_q;

  always_comb begin
    k_idx = phase_i[29 -: TableBits];
    if (phase_i[30]) begin
      rom_idx = (TableBits+1)'(QSize) - {1'b0, k_idx};
    end else begin
      rom_idx = {1'b0, k_idx};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      mag_q <= CosRom[rom_idx];
      neg_q <= phase_i[31] ^ phase_i[30];
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

`default_nettype wire

### design/asfs_frame_mem.sv
// Frame accumulator memory: one read and one write port, registered read,
// per-entry valid bits so unwritten or cleared entries read as zero.
`default_nettype none

module asfs_frame_mem #(
  parameter int Depth = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                rd_en_i,
  input  logic [$clog2(Depth)-1:0]            rd_addr_i,
  input  logic                                clr_en_i,
  output logic signed [asfs_pkg::SAMPLE_W-1:0] rd_data_o,
  input  logic                                wr_en_i,
  input  logic [$clog2(Depth)-1:0]            wr_addr_i,
  input  logic signed [asfs_pkg::SAMPLE_W-1:0] wr_data_i
);

  logic signed [asfs_pkg::SAMPLE_W-1:0] mem [Depth];
  logic signed [asfs_pkg::SAMPLE_W-1:0] rd_q;
  logic                                 rd_vld_q;
  logic [Depth-1:0]                     vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
      if (clr_en_i) begin
        vld_q[rd_addr_i] <= 1'b0;
      end
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

### tb/tb.sv
// Testbench for additive_sine_frame_synth: sends peak words with random idling and
// predicts each emitted frame with its own bit-exact model, checking every sample word.
// Depends on asfs_pkg and the synthesizer RTL.
`timescale 1ns / 100ps

module tb;

  localparam int FRAME_LEN      = 64;
  localparam int COS_TABLE_BITS = 10;
  localparam int QUARTER        = 1 << COS_TABLE_BITS;
  localparam int DRAIN_CYCLES   = 4 * (FRAME_LEN + 12);
  localparam int RAND_PEAKS     = 64;
  localparam longint SAT_MAX    = (64'sd1 <<< (asfs_pkg::SAMPLE_W - 1)) - 1;
  localparam longint SAT_MIN    = -(64'sd1 <<< (asfs_pkg::SAMPLE_W - 1));
  localparam logic [asfs_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  asfs_pkg::peak_t                in_word   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  asfs_pkg::sample_t              out_word;
  logic                           cfg_we    = 1'b0;
  logic [asfs_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [asfs_pkg::CFG_W-1:0]     cfg_wdata = '0;

  // synthesizer model state
  int                cos_lut [0:QUARTER];
  int                frame_acc [FRAME_LEN];
  bit [31:0]         step_per_hz;
  bit [6:0]          start_delay;
  bit [1:0]          harm_cnt;
  bit [15:0]         mul_f1, mul_a1, mul_f2, mul_a2;
  asfs_pkg::sample_t frame_q [$];

  int                err_count  = 0;
  int                stall_left = 0;
  bit                idle_en    = 1'b1;
  asfs_pkg::sample_t want;

  always #5 clk = ~clk;

  additive_sine_frame_synth dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  task automatic report_mismatch(input string what, input logic signed [31:0] want_v,
                                 input logic signed [31:0] got_v);
    err_count++;
    $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want_v, got_v);
  endtask

  // quarter-wave cosine, Q1.16, from a 12-term Taylor series in Q30
  function automatic int cos_entry(input int unsigned k);
    longint unsigned x, x2, term, den;
    longint          acc, v;
    int              n;
    x    = (64'd1686629713 * k) >> COS_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    acc  = 64'sd1 <<< 30;
    for (n = 1; n <= 12; n++) begin
      den  = 64'((2 * n - 1) * (2 * n));
      term = ((term * x2) >> 30) / den;
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    v = (acc + 8192) >>> 14;
    if (v > 65536) v = 65536;
    return int'(v);
  endfunction

  function automatic int cos_of(input bit [31:0] ph);
    int unsigned k;
    k = (ph >> (30 - COS_TABLE_BITS)) & (QUARTER - 1);
    case (ph[31:30])
      2'd0:    return cos_lut[k];
      2'd1:    return -cos_lut[QUARTER - k];
      2'd2:    return -cos_lut[k];
      default: return cos_lut[QUARTER - k];
    endcase
  endfunction

  function automatic void add_sinusoid(input longint unsigned fe, input longint unsigned ae,
                                       input bit [31:0] pbase);
    longint unsigned prod, mag;
    longint          contrib, s;
    bit [31:0]       inc, rel, ph;
    int              c, n;
    if (fe == 0 || ae == 0) return;
    prod = 64'(step_per_hz) * fe;
    inc  = prod[47:16];
    for (n = 0; n < FRAME_LEN; n++) begin
      rel     = 32'(n) - 32'(start_delay);
      ph      = inc * rel + pbase;
      c       = cos_of(ph);
      mag     = ae * 64'(c < 0 ? -c : c);
      contrib = longint'((mag + 64'd65536) >> 17);
      if (c < 0) contrib = -contrib;
      s = longint'(frame_acc[n]) + contrib;
      if (s > SAT_MAX) s = SAT_MAX;
      if (s < SAT_MIN) s = SAT_MIN;
      frame_acc[n] = int'(s);
    end
  endfunction

  function automatic void predict_word(input asfs_pkg::peak_t w);
    bit [31:0]         pbase;
    asfs_pkg::sample_t s;
    int                n;
    pbase = {w.peak_phase, 16'h0000};
    if (w.peak_valid && !w.peak_group[15]) begin
      if (harm_cnt == 0) begin
        add_sinusoid(64'(w.peak_freq) << 8, 64'(w.peak_amp) << 8, pbase);
      end else begin
        add_sinusoid(64'(w.peak_freq) * mul_f1, 64'(w.peak_amp) * mul_a1, pbase);
        if (harm_cnt >= 2) begin
          add_sinusoid(64'(w.peak_freq) * mul_f2, 64'(w.peak_amp) * mul_a2, pbase);
        end
      end
    end
    if (w.last_peak) begin
      for (n = 0; n < FRAME_LEN; n++) begin
        s.sample      = frame_acc[n][asfs_pkg::SAMPLE_W-1:0];
        s.last_sample = (n == FRAME_LEN - 1);
        frame_q.push_back(s);
        frame_acc[n] = 0;
      end
    end
  endfunction

  function automatic asfs_pkg::peak_t mk_peak(input logic vld, input logic [23:0] freq,
                                              input logic [15:0] amp, input logic [15:0] phase,
                                              input logic [15:0] group, input logic last);
    asfs_pkg::peak_t p;
    p.peak_valid = vld;
    p.peak_freq  = freq;
    p.peak_amp   = amp;
    p.peak_phase = phase;
    p.peak_group = group;
    p.last_peak  = last;
    return p;
  endfunction

  function automatic asfs_pkg::peak_t rand_peak();
    asfs_pkg::peak_t p;
    p.peak_valid = 1'b1;
    case ($urandom_range(0, 3))
      0:       p.peak_freq = 24'($urandom_range(0, 24'hFFFFFF));
      1:       p.peak_freq = 24'($urandom_range(0, 255));
      default: p.peak_freq = 24'($urandom_range(24'h000100, 24'h4E2000));
    endcase
    p.peak_amp   = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 16'hFFFF));
    p.peak_phase = 16'($urandom);
    p.peak_group = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(16'h8000, 16'hFFFF))
                                               : 16'($urandom_range(0, 16'h7FFF));
    p.last_peak  = 1'b0;
    return p;
  endfunction

  task automatic send_word(input asfs_pkg::peak_t w);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(w);
  endtask

  task automatic write_reg(input logic [asfs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [asfs_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      asfs_pkg::CFG_PHASE_STEP: step_per_hz = data;
      asfs_pkg::CFG_DELAY:      start_delay = data[6:0];
      asfs_pkg::CFG_HARM_CNT:   harm_cnt    = data[1:0];
      asfs_pkg::CFG_MUL_FREQ_1: mul_f1      = data[15:0];
      asfs_pkg::CFG_MUL_AMP_1:  mul_a1      = data[15:0];
      asfs_pkg::CFG_MUL_FREQ_2: mul_f2      = data[15:0];
      asfs_pkg::CFG_MUL_AMP_2:  mul_a2      = data[15:0];
      default: ;
    endcase
  endtask

  // hold the sender until every frame word is out and the core is idle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_plain_frames();
    send_word(mk_peak(1'b0, 24'h00ABCD, 16'h1234, 16'h5678, 16'h0001, 1'b0));
    send_word(mk_peak(1'b1, 24'h01B800, 16'h8000, 16'h0000, 16'h0000, 1'b0));
    send_word(mk_peak(1'b1, 24'hFFFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 1'b0));
    send_word(mk_peak(1'b1, 24'h003200, 16'hFFFF, 16'h1000, 16'hFFFF, 1'b1));
    send_word(mk_peak(1'b0, 24'h000000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_word(mk_peak(1'b1, 24'h000000, 16'hFFFF, 16'h0000, 16'h0000, 1'b0));
    send_word(mk_peak(1'b1, 24'h0FA000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_word(mk_peak(1'b1, 24'h002000, 16'hFFFF, 16'h8000, 16'h8000, 1'b1));
    // positive then negative saturation
    send_word(mk_peak(1'b1, 24'h000100, 16'hFFFF, 16'h0000, 16'h0003, 1'b0));
    send_word(mk_peak(1'b1, 24'h000100, 16'hFFFF, 16'h0000, 16'h0004, 1'b1));
    send_word(mk_peak(1'b1, 24'h000100, 16'hFFFF, 16'h8000, 16'h0005, 1'b0));
    send_word(mk_peak(1'b1, 24'h000100, 16'hFFFF, 16'h8000, 16'h0006, 1'b1));
    wait_drained();
  endtask

  task automatic test_harmonic_pairs();
    write_reg(asfs_pkg::CFG_HARM_CNT, 32'd1);
    write_reg(asfs_pkg::CFG_MUL_FREQ_1, 32'hFFFF);
    write_reg(asfs_pkg::CFG_MUL_AMP_1, 32'hFFFF);
    send_word(mk_peak(1'b1, 24'h000100, 16'hFFFF, 16'h0000, 16'h0000, 1'b1));
    wait_drained();
    write_reg(asfs_pkg::CFG_MUL_FREQ_1, 32'h0000);
    send_word(mk_peak(1'b1, 24'h01B800, 16'hFFFF, 16'h0000, 16'h0000, 1'b1));
    wait_drained();
    write_reg(asfs_pkg::CFG_MUL_FREQ_1, 32'd256);
    write_reg(asfs_pkg::CFG_MUL_AMP_1, 32'h0000);
    send_word(mk_peak(1'b1, 24'h01B800, 16'hFFFF, 16'h0000, 16'h0000, 1'b1));
    wait_drained();
    write_reg(asfs_pkg::CFG_HARM_CNT, 32'd2);
    write_reg(asfs_pkg::CFG_MUL_AMP_1, 32'd128);
    write_reg(asfs_pkg::CFG_MUL_FREQ_2, 32'hFFFF);
    write_reg(asfs_pkg::CFG_MUL_AMP_2, 32'h0000);
    send_word(mk_peak(1'b1, 24'h01B800, 16'hC000, 16'h2000, 16'h0010, 1'b0));
    send_word(mk_peak(1'b1, 24'h037000, 16'h4000, 16'hE000, 16'h0011, 1'b1));
    wait_drained();
    write_reg(asfs_pkg::CFG_HARM_CNT, 32'd3);
    write_reg(asfs_pkg::CFG_MUL_FREQ_2, 32'h0000);
    write_reg(asfs_pkg::CFG_MUL_AMP_2, 32'hFFFF);
    send_word(mk_peak(1'b1, 24'h01B800, 16'h0100, 16'h0000, 16'h0000, 1'b1));
    wait_drained();
    write_reg(asfs_pkg::CFG_MUL_FREQ_2, 32'd512);
    write_reg(asfs_pkg::CFG_PHASE_STEP, 32'h0);
    write_reg(asfs_pkg::CFG_DELAY, 32'd0);
    send_word(mk_peak(1'b1, 24'h01B800, 16'h8000, 16'h2AAA, 16'h0000, 1'b1));
    wait_drained();
    write_reg(asfs_pkg::CFG_PHASE_STEP, 32'hFFFFFFFF);
    write_reg(asfs_pkg::CFG_DELAY, 32'd64);
    write_reg(CFG_UNMAPPED, 32'hFFFFFFFF);
    send_word(mk_peak(1'b1, 24'h01B800, 16'h8000, 16'h0000, 16'h0000, 1'b1));
    wait_drained();
    write_reg(asfs_pkg::CFG_HARM_CNT, 32'd0);
    write_reg(asfs_pkg::CFG_PHASE_STEP, 32'd97391);
    write_reg(asfs_pkg::CFG_DELAY, 32'd127);
    send_word(mk_peak(1'b1, 24'h0AC400, 16'h8000, 16'h4000, 16'h0000, 1'b1));
    wait_drained();
  endtask

  task automatic randomize_regs();
    int i;
    write_reg(asfs_pkg::CFG_PHASE_STEP, ($urandom_range(0, 3) == 0) ? $urandom
                                                       : $urandom_range(20000, 200000));
    write_reg(asfs_pkg::CFG_DELAY, $urandom_range(0, 127));
    write_reg(asfs_pkg::CFG_HARM_CNT, $urandom_range(0, 3));
    for (i = 0; i < 4; i++) begin
      write_reg(asfs_pkg::CFG_IDX_W'(int'(asfs_pkg::CFG_MUL_FREQ_1) + i),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'hFFFF)
                                            : $urandom_range(64, 1024));
    end
  endtask

  task automatic test_random_frames();
    asfs_pkg::peak_t w;
    int              sent, len, i, next_cfg;
    sent     = 0;
    next_cfg = 0;
    while (sent < RAND_PEAKS) begin
      if (sent >= next_cfg) begin
        wait_drained();
        randomize_regs();
        next_cfg = next_cfg + 16;
      end
      len = $urandom_range(1, 6);
      for (i = 0; i < len; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          w = rand_peak();
          w.peak_valid = 1'b0;
          send_word(w);
        end
        w = rand_peak();
        if (i == len - 1) begin
          w.last_peak = 1'b1;
          if ($urandom_range(0, 9) == 0) w.peak_valid = 1'b0;
        end
        send_word(w);
        sent++;
      end
    end
    wait_drained();
  endtask

  task automatic test_back_to_back();
    asfs_pkg::peak_t w;
    int              f, i;
    idle_en = 1'b0;
    randomize_regs();
    for (f = 0; f < 3; f++) begin
      for (i = 0; i < 3; i++) begin
        w = rand_peak();
        w.last_peak = (i == 2);
        send_word(w);
      end
    end
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (frame_q.size() == 0) begin
          report_mismatch("unexpected sample word", 0, out_word.sample);
        end else begin
          want = frame_q.pop_front();
          if (out_word.sample !== want.sample) begin
            report_mismatch("sample", want.sample, out_word.sample);
          end
          if (out_word.last_sample !== want.last_sample) begin
            report_mismatch("last_sample", want.last_sample, out_word.last_sample);
          end
        end
      end
      if (stall_left > 0) stall_left = stall_left - 1;
      else if (idle_en && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 5);
      out_ready <= (stall_left == 0);
    end
  end

  initial begin
    int k;
    for (k = 0; k <= QUARTER; k++) cos_lut[k] = cos_entry(k);
    for (k = 0; k < FRAME_LEN; k++) frame_acc[k] = 0;
    step_per_hz = 32'd97391;
    start_delay = 7'd32;
    harm_cnt    = 2'd0;
    mul_f1      = asfs_pkg::UNITY_MUL;
    mul_a1      = asfs_pkg::UNITY_MUL;
    mul_f2      = asfs_pkg::UNITY_MUL;
    mul_a2      = asfs_pkg::UNITY_MUL;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_plain_frames();
    test_harmonic_pairs();
    test_random_frames();
    test_back_to_back();
    if (frame_q.size() != 0) report_mismatch("missing sample words", frame_q.size(), 0);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/asfs_pkg.sv
design/asfs_mult.sv
design/asfs_cos_rom.sv
design/asfs_frame_mem.sv
design/additive_sine_frame_synth.sv
tb/tb.sv
